>>> sv/lgrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lgrs_pkg: shared types for the Life row stencil
// Word formats, cell control group and queue sizing.
// ----------------------------------------------------------------------------
package lgrs_pkg;

    localparam int ROW_W   = 64;
    localparam int CFG_W   = 7;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [ROW_W-1:0] row_bits;
        logic             first_row;
        logic             last_row;
    } src_word_t;

    typedef struct packed {
        logic [ROW_W-1:0] next_row;
        logic             last_out;
    } dst_word_t;

    typedef struct packed {
        logic load;
        logic start;
        logic last;
    } cell_ctl_t;

endpackage
`default_nettype wire

>>> sv/life_generation_row_stencil_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// life_generation_row_stencil_top: one Life generation (B3/S23), row stream
// A chain of column cells holds the two buffered rows; each row word after the
// first yields the next-generation row above it; the bottom row yields two.
//
//   channel | handshake              | word
//   src     | src_valid / src_ready  | src_word  (row_bits, first_row, last_row)
//   dst     | dst_valid / dst_ready  | dst_word  (next_row, last_out)
//   cfg     | cfg_we                 | cfg_data  (board_width)
//
// One row word per cycle while src_ready is high; results enter the queue.
// The bottom row pushes two words into the output queue, so src_ready drops
// while more than two words are queued (four-entry queue sets this).
// Reset empties the queue and the row buffer; board_width returns to
// BOARD_WIDTH. A stalled dst side holds words in the queue, not in the cells.
// ----------------------------------------------------------------------------
module life_generation_row_stencil_top #(
    parameter int BOARD_WIDTH = 64
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    src_valid,
    output logic                         src_ready,
    input  wire lgrs_pkg::src_word_t     src_word,
    output logic                         dst_valid,
    input  wire logic                    dst_ready,
    output lgrs_pkg::dst_word_t          dst_word,
    input  wire logic                    cfg_we,
    input  wire logic [lgrs_pkg::CFG_W-1:0] cfg_data
);
    import lgrs_pkg::*;

    logic [CFG_W-1:0]       board_width_reg;
    logic                   empty_reg;
    logic                   empty_next;
    cell_ctl_t              ctl;
    logic                   room;
    logic [BOARD_WIDTH-1:0] active;
    logic [BOARD_WIDTH-1:0] row_m;
    logic [BOARD_WIDTH+1:0] u_pad;
    logic [BOARD_WIDTH+1:0] m_pad;
    logic [BOARD_WIDTH+1:0] r_pad;
    logic [BOARD_WIDTH-1:0] own_u;
    logic [BOARD_WIDTH-1:0] own_m;
    logic [ROW_W-1:0]       next_a;
    logic [ROW_W-1:0]       next_b;
    logic [1:0]             push_n;
    dst_word_t              push_w0;
    dst_word_t              push_w1;

    assign src_ready = room;
    assign ctl.load  = src_valid & src_ready;
    assign ctl.start = src_word.first_row | empty_reg;
    assign ctl.last  = src_word.last_row;

    assign u_pad = {1'b0, own_u, 1'b0};
    assign m_pad = {1'b0, own_m, 1'b0};
    assign r_pad = {1'b0, row_m, 1'b0};

    for (genvar j = 0; j < BOARD_WIDTH; j++)
    begin : g_col
        assign active[j] = board_width_reg > CFG_W'(j);
        assign row_m[j]  = src_word.row_bits[j] & active[j];

        lgrs_cell u_cell (
            .clk    (clk),
            .ctl    (ctl),
            .active (active[j]),
            .row_in (row_m[j]),
            .lft_u  (u_pad[j]),
            .lft_m  (m_pad[j]),
            .lft_r  (r_pad[j]),
            .rgt_u  (u_pad[j+2]),
            .rgt_m  (m_pad[j+2]),
            .rgt_r  (r_pad[j+2]),
            .own_u  (own_u[j]),
            .own_m  (own_m[j]),
            .next_a (next_a[j]),
            .next_b (next_b[j])
        );
    end

    if (BOARD_WIDTH < ROW_W)
    begin : g_dead
        assign next_a[ROW_W-1:BOARD_WIDTH] = '0;
        assign next_b[ROW_W-1:BOARD_WIDTH] = '0;
    end

    always_comb
    begin
        push_w1.next_row = next_b;
        push_w1.last_out = 1'b1;
        push_n           = 2'd0;
        if (ctl.start)
        begin
            push_w0 = push_w1;
            if (ctl.load && ctl.last)
            begin
                push_n = 2'd1;
            end
        end
        else
        begin
            push_w0.next_row = next_a;
            push_w0.last_out = 1'b0;
            if (ctl.load)
            begin
                push_n = ctl.last ? 2'd2 : 2'd1;
            end
        end
    end

    always_comb
    begin
        empty_next = empty_reg;
        if (ctl.load)
        begin
            empty_next = ctl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_width_reg <= CFG_W'(BOARD_WIDTH);
            empty_reg       <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                board_width_reg <= cfg_data;
            end
            empty_reg <= empty_next;
        end
    end

    lgrs_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_w0   (push_w0),
        .push_w1   (push_w1),
        .room      (room),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_word  (dst_word)
    );

endmodule
`default_nettype wire

>>> sv/lgrs_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lgrs_cell: one board column
// Holds the column bit of the two buffered rows, trades bits with both
// neighbors and produces the column bit of both possible result rows.
// ----------------------------------------------------------------------------
module lgrs_cell (
    input  wire logic              clk,
    input  wire lgrs_pkg::cell_ctl_t ctl,
    input  wire logic              active,
    input  wire logic              row_in,
    input  wire logic              lft_u,
    input  wire logic              lft_m,
    input  wire logic              lft_r,
    input  wire logic              rgt_u,
    input  wire logic              rgt_m,
    input  wire logic              rgt_r,
    output logic                   own_u,
    output logic                   own_m,
    output logic                   next_a,
    output logic                   next_b
);
    import lgrs_pkg::*;

    logic upper_reg;
    logic upper_next;
    logic middle_reg;
    logic middle_next;
    logic [7:0] nbr_a;
    logic [7:0] nbr_b;
    logic ab_l;
    logic ab_c;
    logic ab_r;

    function automatic logic life_bit(input logic [7:0] nbrs, input logic self);
        logic [3:0] cnt;
        cnt = '0;
        for (int k = 0; k < 8; k++)
        begin
            cnt = cnt + {3'b000, nbrs[k]};
        end
        return (cnt == 4'd3) || (self && (cnt == 4'd2));
    endfunction

    assign own_u = upper_reg & active;
    assign own_m = middle_reg & active;

    // neighbors of the middle held row: rows above and below it, and its sides
    assign nbr_a = {lft_u, own_u, rgt_u, lft_m, rgt_m, lft_r, row_in, rgt_r};

    // new bottom row: above is the held middle row, or dead on a new board
    assign ab_l  = lft_m & ~ctl.start;
    assign ab_c  = own_m & ~ctl.start;
    assign ab_r  = rgt_m & ~ctl.start;
    assign nbr_b = {ab_l, ab_c, ab_r, lft_r, rgt_r, 3'b000};

    assign next_a = active & life_bit(nbr_a, own_m);
    assign next_b = active & life_bit(nbr_b, row_in);

    always_comb
    begin
        upper_next  = upper_reg;
        middle_next = middle_reg;
        if (ctl.load)
        begin
            if (ctl.last)
            begin
                upper_next  = 1'b0;
                middle_next = 1'b0;
            end
            else if (ctl.start)
            begin
                upper_next  = 1'b0;
                middle_next = row_in;
            end
            else
            begin
                upper_next  = middle_reg;
                middle_next = row_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        upper_reg  <= upper_next;
        middle_reg <= middle_next;
    end

endmodule
`default_nettype wire

>>> sv/lgrs_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lgrs_out_queue: result word queue
// Four-entry queue taking up to two words per cycle, giving one if dst_ready.
// ----------------------------------------------------------------------------
module lgrs_out_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [1:0]           push_n,
    input  wire lgrs_pkg::dst_word_t  push_w0,
    input  wire lgrs_pkg::dst_word_t  push_w1,
    output logic                      room,
    output logic                      dst_valid,
    input  wire logic                 dst_ready,
    output lgrs_pkg::dst_word_t       dst_word
);
    import lgrs_pkg::*;

    dst_word_t            mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic [Q_PTR_W-1:0]   wr_ptr_plus1;
    logic                 pop;

    assign room         = count_reg <= Q_CNT_W'(Q_DEPTH - 2);
    assign dst_valid    = count_reg != '0;
    assign dst_word     = mem_reg[rd_ptr_reg];
    assign pop          = dst_valid & dst_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + Q_PTR_W'(1);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push_n);
        count_next  = count_reg + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_w0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push_w1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[Q_PTR_W-1:0])
        else $error("queue pointers disagree with count");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> room)
        else $error("push into a queue without room");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (push_n == 2'd0)) |=> (count_reg == $past(count_reg) - Q_CNT_W'(1)))
        else $error("pop did not drain one word");

endmodule
`default_nettype wire
